>>> design/rmq_pkg.sv
// Shared types and constants of the round-ordered message queue.
// No dependencies; every other file of the block imports it.
package rmq_pkg;

    localparam int KIND_BITS   = 4;
    localparam int ACTION_BITS = 2;

    localparam logic [ACTION_BITS-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACTION_BITS-1:0] ACT_REMOVE = 2'd1;
    localparam logic [ACTION_BITS-1:0] ACT_QUERY  = 2'd2;

    // Sequencer states of the insert walk and head read
    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SHIFT,
        S_PUT,
        S_HEAD,
        S_DONE
    } state_t;

endpackage

>>> design/rmq_if.sv
// Valid/ready channel interfaces for request and result beats.
// Depends on rmq_pkg for the kind and action widths.
interface rmq_req_if #(
    parameter int ROUND_BITS   = 16,
    parameter int NODE_BITS    = 8,
    parameter int PAYLOAD_BITS = 32
);
    import rmq_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [ACTION_BITS-1:0]  action;
    logic [ROUND_BITS-1:0]   msg_round;
    logic [NODE_BITS-1:0]    msg_node;
    logic [KIND_BITS-1:0]    msg_kind;
    logic [PAYLOAD_BITS-1:0] msg_payload;

    modport source (
        output valid, action, msg_round, msg_node, msg_kind, msg_payload,
        input  ready
    );
    modport sink (
        input  valid, action, msg_round, msg_node, msg_kind, msg_payload,
        output ready
    );
endinterface

interface rmq_res_if #(
    parameter int ROUND_BITS   = 16,
    parameter int NODE_BITS    = 8,
    parameter int PAYLOAD_BITS = 32,
    parameter int COUNT_BITS   = 5
);
    import rmq_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    head_valid;
    logic [ROUND_BITS-1:0]   head_round;
    logic [NODE_BITS-1:0]    head_node;
    logic [KIND_BITS-1:0]    head_kind;
    logic [PAYLOAD_BITS-1:0] head_payload;
    logic [COUNT_BITS-1:0]   entry_count;
    logic                    rejected;

    modport source (
        output valid, head_valid, head_round, head_node, head_kind, head_payload,
               entry_count, rejected,
        input  ready
    );
    modport sink (
        input  valid, head_valid, head_round, head_node, head_kind, head_payload,
               entry_count, rejected,
        output ready
    );
endinterface

>>> design/round_ordered_message_queue_core.sv
// Round-ordered message queue: head of a sorted ring store with an insert walk.
// Depends on rmq_pkg, rmq_req_if, rmq_res_if and rmq_out_stage.
//
// Usage:
//   request carries one beat per operation: insert a message (action 0),
//   remove the head (action 1) or query (action 2, code 3 acts as query).
//   result returns one beat per request: the head entry after the update,
//   head_valid, entry_count and rejected (insert into a full queue, removal
//   from an empty one). Equal keys stay in arrival order.
// Sequence:
//   entries live in a single ring memory with a registered read port.
//   Remove, query and a rejected insert go straight to the head read. An
//   insert walks back from the tail, moving one entry per cycle through the
//   memory's read and write ports: each stored entry whose key is larger
//   than the new one (at most QUEUE_DEPTH - 1) moves up one slot, then the
//   new entry is written and the head is read; an insert into an empty
//   queue skips the walk. One request is in progress at a time;
//   request.ready is high when idle.
// Reset:
//   the queue is empty after reset; memory contents are not cleared.
// Stall:
//   a finished result waits in the output register; the next request is
//   accepted meanwhile and its result waits until the register frees.
module round_ordered_message_queue_core #(
    parameter int QUEUE_DEPTH  = 16,
    parameter int ROUND_BITS   = 16,
    parameter int NODE_BITS    = 8,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    rmq_req_if.sink   request,
    rmq_res_if.source result
);
    import rmq_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int EW = ROUND_BITS + NODE_BITS + KIND_BITS + PAYLOAD_BITS;

    localparam logic [AW-1:0] LAST_PTR = AW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

    // Ring pointer helpers, wrapping at any depth
    function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
        return (p == LAST_PTR) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [AW-1:0] ptr_prev(input logic [AW-1:0] p);
        return (p == '0) ? LAST_PTR : p - 1'b1;
    endfunction

    // Entry store and its registered read port
    logic [EW-1:0] store_mem [QUEUE_DEPTH];
    logic [EW-1:0] rd_data_reg;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [EW-1:0] wr_data;

    state_t        state_reg, state_next;
    logic [AW-1:0] hd_reg, hd_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic [CW-1:0] left_reg, left_next;
    logic [EW-1:0] fresh_reg, fresh_next;
    logic          rej_reg, rej_next;

    logic [AW:0]           tail_sum;
    logic [AW-1:0]         tail_ptr;
    logic [ROUND_BITS-1:0] rd_round, fresh_round;
    logic [NODE_BITS-1:0]  rd_node, fresh_node;
    logic                  stays_ahead;
    logic                  out_load;
    logic                  out_free;
    logic                  head_live;
    logic [EW-1:0]         head_word;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    // Physical slot just past the last entry
    assign tail_sum = (AW+1)'(hd_reg) + (AW+1)'(count_reg);
    assign tail_ptr = (tail_sum >= (AW+1)'(QUEUE_DEPTH))
                      ? AW'(tail_sum - (AW+1)'(QUEUE_DEPTH)) : tail_sum[AW-1:0];

    // Stored entry stays ahead when its key is not larger than the new one
    assign rd_round    = rd_data_reg[EW-1 -: ROUND_BITS];
    assign rd_node     = rd_data_reg[EW-1-ROUND_BITS -: NODE_BITS];
    assign fresh_round = fresh_reg[EW-1 -: ROUND_BITS];
    assign fresh_node  = fresh_reg[EW-1-ROUND_BITS -: NODE_BITS];
    assign stays_ahead = (rd_round < fresh_round) ||
                         ((rd_round == fresh_round) && (rd_node <= fresh_node));

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            hd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            hd_reg    <= hd_next;
            count_reg <= count_next;
        end
    end

    // Walk and request registers
    always_ff @(posedge clk)
    begin
        pos_reg   <= pos_next;
        left_reg  <= left_next;
        fresh_reg <= fresh_next;
        rej_reg   <= rej_next;
    end

    // Sequence the operation
    always_comb
    begin
        state_next    = state_reg;
        hd_next       = hd_reg;
        count_next    = count_reg;
        pos_next      = pos_reg;
        left_next     = left_reg;
        fresh_next    = fresh_reg;
        rej_next      = rej_reg;
        rd_en         = 1'b0;
        rd_addr       = hd_reg;
        wr_en         = 1'b0;
        wr_addr       = pos_reg;
        wr_data       = fresh_reg;
        out_load      = 1'b0;
        request.ready = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                request.ready = 1'b1;
                if (request.valid)
                begin
                    fresh_next = {request.msg_round, request.msg_node,
                                  request.msg_kind, request.msg_payload};
                    rej_next   = 1'b0;
                    state_next = S_HEAD;
                    if (request.action == ACT_INSERT)
                    begin
                        if (count_reg == FULL_CNT)
                        begin
                            rej_next = 1'b1;
                        end
                        else
                        begin
                            pos_next   = tail_ptr;
                            left_next  = count_reg;
                            count_next = count_reg + 1'b1;
                            state_next = (count_reg == '0) ? S_PUT : S_READ;
                        end
                    end
                    else if (request.action == ACT_REMOVE)
                    begin
                        if (count_reg == '0)
                        begin
                            rej_next = 1'b1;
                        end
                        else
                        begin
                            hd_next    = ptr_next(hd_reg);
                            count_next = count_reg - 1'b1;
                        end
                    end
                end
            end
            S_READ:
            begin
                rd_en      = 1'b1;
                rd_addr    = ptr_prev(pos_reg);
                state_next = S_SHIFT;
            end
            S_SHIFT:
            begin
                wr_en = 1'b1;
                if (stays_ahead)
                begin
                    state_next = S_HEAD;
                end
                else
                begin
                    // Move the larger entry up one slot, fetch the next one
                    wr_data   = rd_data_reg;
                    pos_next  = ptr_prev(pos_reg);
                    left_next = left_reg - 1'b1;
                    if (left_reg > CW'(1))
                    begin
                        rd_en   = 1'b1;
                        rd_addr = ptr_prev(ptr_prev(pos_reg));
                    end
                    else
                    begin
                        state_next = S_PUT;
                    end
                end
            end
            S_PUT:
            begin
                wr_en      = 1'b1;
                state_next = S_HEAD;
            end
            S_HEAD:
            begin
                rd_en      = 1'b1;
                rd_addr    = hd_reg;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Zero the head fields of an empty queue
    assign head_live = (count_reg != '0);
    assign head_word = head_live ? rd_data_reg : '0;

    rmq_out_stage #(
        .ROUND_BITS   (ROUND_BITS),
        .NODE_BITS    (NODE_BITS),
        .PAYLOAD_BITS (PAYLOAD_BITS),
        .COUNT_BITS   (CW)
    ) u_out_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (out_load),
        .head_valid   (head_live),
        .head_round   (head_word[EW-1 -: ROUND_BITS]),
        .head_node    (head_word[EW-1-ROUND_BITS -: NODE_BITS]),
        .head_kind    (head_word[PAYLOAD_BITS +: KIND_BITS]),
        .head_payload (head_word[PAYLOAD_BITS-1:0]),
        .entry_count  (count_reg),
        .rejected     (rej_reg),
        .free         (out_free),
        .result       (result)
    );

`ifndef SYNTHESIS
    // Count never passes the depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("entry count above queue depth");

    // A shift step always has an entry left to examine
    a_shift_left: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT) |-> (left_reg != '0))
        else $error("shift step with no entry left");

    // Store writes happen only during the insert walk
    a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> ((state_reg == S_SHIFT) || (state_reg == S_PUT)))
        else $error("store written outside insert walk");

    // Handing a result over returns the sequencer to idle
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (state_reg == S_IDLE))
        else $error("sequencer not idle after result load");
`endif

endmodule

>>> design/rmq_out_stage.sv
// Output register of the result channel: holds one result beat until taken.
// Depends on rmq_pkg and rmq_res_if.
module rmq_out_stage #(
    parameter int ROUND_BITS   = 16,
    parameter int NODE_BITS    = 8,
    parameter int PAYLOAD_BITS = 32,
    parameter int COUNT_BITS   = 5
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           load,
    input  logic                           head_valid,
    input  logic [ROUND_BITS-1:0]          head_round,
    input  logic [NODE_BITS-1:0]           head_node,
    input  logic [rmq_pkg::KIND_BITS-1:0]  head_kind,
    input  logic [PAYLOAD_BITS-1:0]        head_payload,
    input  logic [COUNT_BITS-1:0]          entry_count,
    input  logic                           rejected,
    output logic                           free,
    rmq_res_if.source                      result
);
    import rmq_pkg::*;

    logic                    valid_reg;
    logic                    head_valid_reg;
    logic [ROUND_BITS-1:0]   head_round_reg;
    logic [NODE_BITS-1:0]    head_node_reg;
    logic [KIND_BITS-1:0]    head_kind_reg;
    logic [PAYLOAD_BITS-1:0] head_payload_reg;
    logic [COUNT_BITS-1:0]   entry_count_reg;
    logic                    rejected_reg;

    // Slot is free when empty or when the held beat leaves this cycle
    assign free = !valid_reg || result.ready;

    // Hold the beat flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Capture the payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            head_valid_reg   <= head_valid;
            head_round_reg   <= head_round;
            head_node_reg    <= head_node;
            head_kind_reg    <= head_kind;
            head_payload_reg <= head_payload;
            entry_count_reg  <= entry_count;
            rejected_reg     <= rejected;
        end
    end

    assign result.valid        = valid_reg;
    assign result.head_valid   = head_valid_reg;
    assign result.head_round   = head_round_reg;
    assign result.head_node    = head_node_reg;
    assign result.head_kind    = head_kind_reg;
    assign result.head_payload = head_payload_reg;
    assign result.entry_count  = entry_count_reg;
    assign result.rejected     = rejected_reg;

endmodule

>>> sim/rmq_order_checker.sv
`timescale 1ns / 100ps
// Order checker for the round-ordered message queue: watches both channels,
// keeps its own sorted copy of the store and compares every result beat.
// Depends on rmq_pkg for the action codes and field widths.
module rmq_order_checker #(
    parameter int QUEUE_DEPTH  = 16,
    parameter int ROUND_BITS   = 16,
    parameter int NODE_BITS    = 8,
    parameter int PAYLOAD_BITS = 32,
    parameter int COUNT_BITS   = 5
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    input  logic                             req_ready,
    input  logic [rmq_pkg::ACTION_BITS-1:0]  req_action,
    input  logic [ROUND_BITS-1:0]            req_round,
    input  logic [NODE_BITS-1:0]             req_node,
    input  logic [rmq_pkg::KIND_BITS-1:0]    req_kind,
    input  logic [PAYLOAD_BITS-1:0]          req_payload,
    input  logic                             res_valid,
    input  logic                             res_ready,
    input  logic                             res_head_valid,
    input  logic [ROUND_BITS-1:0]            res_head_round,
    input  logic [NODE_BITS-1:0]             res_head_node,
    input  logic [rmq_pkg::KIND_BITS-1:0]    res_head_kind,
    input  logic [PAYLOAD_BITS-1:0]          res_head_payload,
    input  logic [COUNT_BITS-1:0]            res_entry_count,
    input  logic                             res_rejected,
    output int                               fail_count,
    output int                               pending_count
);
    import rmq_pkg::*;

    typedef struct packed {
        logic [ROUND_BITS-1:0]   round;
        logic [NODE_BITS-1:0]    node;
        logic [KIND_BITS-1:0]    kind;
        logic [PAYLOAD_BITS-1:0] payload;
    } queued_msg_t;

    typedef struct packed {
        logic                  head_valid;
        queued_msg_t           head;
        logic [COUNT_BITS-1:0] count;
        logic                  rejected;
    } head_view_t;

    // Sorted copy of the store, smallest key at index 0
    queued_msg_t held [QUEUE_DEPTH];
    int          held_count;
    head_view_t  views_due [$];

    initial
    begin
        fail_count    = 0;
        pending_count = 0;
        held_count    = 0;
    end

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t: %s", $realtime, what);
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
    endtask

    // True when entry a stays ahead of entry b: key of a not larger than b
    function automatic bit key_not_after(input queued_msg_t a, input queued_msg_t b);
        if (a.round != b.round)
            return a.round < b.round;
        return a.node <= b.node;
    endfunction

    // Apply one request to the held copy and return the head it leaves
    function automatic head_view_t order_request(input logic [ACTION_BITS-1:0] act,
                                                 input queued_msg_t fresh);
        head_view_t view;
        int         pos;
        view = '0;
        if (act == ACT_INSERT)
        begin
            if (held_count >= QUEUE_DEPTH)
                view.rejected = 1'b1;
            else
            begin
                // Walk back from the tail; equal keys stay ahead of the newcomer
                pos = held_count;
                while (pos > 0 && !key_not_after(held[pos-1], fresh))
                begin
                    held[pos] = held[pos-1];
                    pos--;
                end
                held[pos] = fresh;
                held_count++;
            end
        end
        else if (act == ACT_REMOVE)
        begin
            if (held_count == 0)
                view.rejected = 1'b1;
            else
            begin
                for (int i = 0; i < held_count - 1; i++)
                    held[i] = held[i+1];
                held_count--;
            end
        end
        if (held_count > 0)
        begin
            view.head_valid = 1'b1;
            view.head       = held[0];
        end
        view.count = COUNT_BITS'(held_count);
        return view;
    endfunction

    // Record request beats, compare result beats with the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        head_view_t  want;
        queued_msg_t fresh;
        if (!rst_n)
        begin
            held_count = 0;
            views_due.delete();
        end
        else
        begin
            if (req_valid && req_ready)
            begin
                fresh.round   = req_round;
                fresh.node    = req_node;
                fresh.kind    = req_kind;
                fresh.payload = req_payload;
                views_due.push_back(order_request(req_action, fresh));
            end
            if (res_valid && res_ready)
            begin
                if (views_due.size() == 0)
                    report_mismatch("result beat with no request outstanding");
                else
                begin
                    want = views_due.pop_front();
                    check_field("head_valid", 64'(res_head_valid), 64'(want.head_valid));
                    check_field("head_round", 64'(res_head_round), 64'(want.head.round));
                    check_field("head_node", 64'(res_head_node), 64'(want.head.node));
                    check_field("head_kind", 64'(res_head_kind), 64'(want.head.kind));
                    check_field("head_payload", 64'(res_head_payload),
                                64'(want.head.payload));
                    check_field("entry_count", 64'(res_entry_count), 64'(want.count));
                    check_field("rejected", 64'(res_rejected), 64'(want.rejected));
                end
            end
        end
        pending_count <= views_due.size();
    end

endmodule

>>> sim/tb_round_ordered_message_queue_core.sv
`timescale 1ns / 100ps
// Testbench top of the round-ordered message queue: clock, reset, request
// bursts, result stalls and the verdict. Depends on rmq_pkg, rmq_req_if,
// rmq_res_if, the core and rmq_order_checker.
module tb_round_ordered_message_queue_core;
    import rmq_pkg::*;

    localparam int QUEUE_DEPTH  = 16;
    localparam int ROUND_BITS   = 16;
    localparam int NODE_BITS    = 8;
    localparam int PAYLOAD_BITS = 32;
    localparam int COUNT_BITS   = 5;
    localparam int RANDOM_ITEMS = 1700;

    // Unused action code, handled as a query
    localparam logic [ACTION_BITS-1:0] ACT_SPARE = 2'd3;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending_count;
    int   burst_left;

    rmq_req_if #(
        .ROUND_BITS  (ROUND_BITS),
        .NODE_BITS   (NODE_BITS),
        .PAYLOAD_BITS(PAYLOAD_BITS)
    ) req_ch ();

    rmq_res_if #(
        .ROUND_BITS  (ROUND_BITS),
        .NODE_BITS   (NODE_BITS),
        .PAYLOAD_BITS(PAYLOAD_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) res_ch ();

    round_ordered_message_queue_core #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ROUND_BITS  (ROUND_BITS),
        .NODE_BITS   (NODE_BITS),
        .PAYLOAD_BITS(PAYLOAD_BITS)
    ) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .request(req_ch),
        .result (res_ch)
    );

    rmq_order_checker #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ROUND_BITS  (ROUND_BITS),
        .NODE_BITS   (NODE_BITS),
        .PAYLOAD_BITS(PAYLOAD_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) order_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_ch.valid),
        .req_ready       (req_ch.ready),
        .req_action      (req_ch.action),
        .req_round       (req_ch.msg_round),
        .req_node        (req_ch.msg_node),
        .req_kind        (req_ch.msg_kind),
        .req_payload     (req_ch.msg_payload),
        .res_valid       (res_ch.valid),
        .res_ready       (res_ch.ready),
        .res_head_valid  (res_ch.head_valid),
        .res_head_round  (res_ch.head_round),
        .res_head_node   (res_ch.head_node),
        .res_head_kind   (res_ch.head_kind),
        .res_head_payload(res_ch.head_payload),
        .res_entry_count (res_ch.entry_count),
        .res_rejected    (res_ch.rejected),
        .fail_count      (fail_count),
        .pending_count   (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Bound the run well beyond the slowest legal one
    initial
    begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

    // Stall the result side: ready runs, short and long stalls, free stretches
    initial
    begin : result_stall
        int run;
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            run = $urandom_range(1, 24);
            if ($urandom_range(0, 9) == 0)
                run = $urandom_range(100, 300);
            res_ch.ready <= 1'b1;
            repeat (run) @(posedge clk);
            run = $urandom_range(1, 6);
            if ($urandom_range(0, 7) == 0)
                run = $urandom_range(20, 40);
            res_ch.ready <= 1'b0;
            repeat (run) @(posedge clk);
        end
    end

    // Drive one request beat and hold it until accepted; close bursts with a gap
    task automatic push_request(input logic [ACTION_BITS-1:0]  act,
                                input logic [ROUND_BITS-1:0]   rnd,
                                input logic [NODE_BITS-1:0]    nid,
                                input logic [KIND_BITS-1:0]    knd,
                                input logic [PAYLOAD_BITS-1:0] pay);
        req_ch.valid       <= 1'b1;
        req_ch.action      <= act;
        req_ch.msg_round   <= rnd;
        req_ch.msg_node    <= nid;
        req_ch.msg_kind    <= knd;
        req_ch.msg_payload <= pay;
        do
            @(posedge clk);
        while (!req_ch.ready);
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            // Drop valid and leave junk on the idle payload
            req_ch.valid       <= 1'b0;
            req_ch.action      <= ACTION_BITS'($urandom);
            req_ch.msg_round   <= ROUND_BITS'($urandom);
            req_ch.msg_node    <= NODE_BITS'($urandom);
            req_ch.msg_kind    <= KIND_BITS'($urandom);
            req_ch.msg_payload <= PAYLOAD_BITS'($urandom);
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = $urandom_range(1, 16);
            if ($urandom_range(0, 7) == 0)
                burst_left = $urandom_range(60, 200);
        end
    endtask

    initial
    begin : stimulus
        int                      ins_pct;
        int                      pick;
        int                      sent;
        logic [ACTION_BITS-1:0]  act;
        logic [ROUND_BITS-1:0]   rnd;
        logic [NODE_BITS-1:0]    nid;

        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.action      = ACT_QUERY;
        req_ch.msg_round   = '0;
        req_ch.msg_node    = '0;
        req_ch.msg_kind    = '0;
        req_ch.msg_payload = '0;
        burst_left         = $urandom_range(1, 8);
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty queue: query, removal rejected, spare code
        push_request(ACT_QUERY, '1, '1, '1, '1);
        push_request(ACT_REMOVE, '0, '0, '0, '0);
        push_request(ACT_SPARE, '1, '0, '1, '0);
        // Key extremes, a new head, and equal keys kept in arrival order
        push_request(ACT_INSERT, '1, '1, '1, '1);
        push_request(ACT_INSERT, '0, '0, '0, '0);
        push_request(ACT_INSERT, '0, '0, '1, 32'hA5A5_A5A5);
        push_request(ACT_REMOVE, '0, '0, '0, '0);
        push_request(ACT_INSERT, '0, '0, 4'h3, 32'h5A5A_5A5A);
        push_request(ACT_INSERT, '1, '1, 4'h6, 32'h0000_0001);
        push_request(ACT_INSERT, '0, '1, 4'h9, 32'h8000_0000);
        push_request(ACT_INSERT, '1, '0, 4'hC, 32'h7FFF_FFFF);
        // Fill to the brim, then push into a full queue
        repeat (QUEUE_DEPTH - 6)
            push_request(ACT_INSERT, ROUND_BITS'($urandom), NODE_BITS'($urandom),
                         KIND_BITS'($urandom), PAYLOAD_BITS'($urandom));
        push_request(ACT_INSERT, '0, '0, '1, '1);
        push_request(ACT_SPARE, '0, '0, '0, '0);
        push_request(ACT_QUERY, '0, '0, '0, '0);
        push_request(ACT_REMOVE, '1, '1, '1, '1);

        // Random phases biased to fill, drain or hover, so full and empty recur
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 2))
                0:       ins_pct = 75;
                1:       ins_pct = 20;
                default: ins_pct = 48;
            endcase
            repeat ($urandom_range(10, 60))
            begin
                pick = $urandom_range(0, 99);
                if (pick < ins_pct)
                    act = ACT_INSERT;
                else if (pick < 90)
                    act = ACT_REMOVE;
                else if (pick < 97)
                    act = ACT_QUERY;
                else
                    act = ACT_SPARE;
                // Close keys half the time to provoke ties
                case ($urandom_range(0, 5))
                    0, 1, 2:
                    begin
                        rnd = ROUND_BITS'($urandom_range(0, 3));
                        nid = NODE_BITS'($urandom_range(0, 3));
                    end
                    3:
                    begin
                        rnd = $urandom_range(0, 1) ? '1 : '0;
                        nid = $urandom_range(0, 1) ? '1 : '0;
                    end
                    default:
                    begin
                        rnd = ROUND_BITS'($urandom);
                        nid = NODE_BITS'($urandom);
                    end
                endcase
                push_request(act, rnd, nid, KIND_BITS'($urandom), PAYLOAD_BITS'($urandom));
                sent++;
            end
        end
        req_ch.valid <= 1'b0;

        // Drain outstanding results, then allow the block to settle
        do
            @(posedge clk);
        while (pending_count != 0);
        repeat (30) @(posedge clk);

        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> sim.f
design/rmq_pkg.sv
design/rmq_if.sv
design/rmq_out_stage.sv
design/round_ordered_message_queue_core.sv
sim/rmq_order_checker.sv
sim/tb_round_ordered_message_queue_core.sv
